[rtl/core/gtg_pkg.sv]
// Shared types, constants and the arctangent table for the go-to-goal controller.
// No dependencies.
package gtg_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int SQRT_STAGES       = 17;
	localparam int DW                = 17;
	localparam int XW                = 28;
	localparam int ZW                = 32;
	localparam int CFG_AW            = 3;

	localparam logic signed [ZW-1:0] HALF_PI_Q29 = 32'sd843314857;

	localparam logic [15:0] RST_TARGET_X     = 16'd20480;
	localparam logic [15:0] RST_TARGET_Y     = 16'd20480;
	localparam logic [15:0] RST_LINEAR_GAIN  = 16'd2048;
	localparam logic [15:0] RST_ANGULAR_GAIN = 16'd8192;
	localparam logic [15:0] RST_STOP_THR     = 16'd20;

	typedef enum logic [CFG_AW-1:0] {
		REG_TARGET_X,
		REG_TARGET_Y,
		REG_LINEAR_GAIN,
		REG_ANGULAR_GAIN,
		REG_STOP_THR
	} cfg_reg_t;

	typedef enum logic [1:0] {
		QD_RIGHT,
		QD_LEFT_UP,
		QD_LEFT_DOWN
	} quad_t;

	typedef struct packed {
		logic signed [DW-1:0] dx;
		logic signed [DW-1:0] dy;
		logic signed [15:0]   heading;
		logic                 zero;
		quad_t                quad;
	} item_t;

	// atan(2^-i) in Q2.29
	function automatic logic signed [ZW-1:0] atan_q29(input logic [4:0] i);
		logic signed [ZW-1:0] a;
		unique case (i)
			5'd0:  a = 32'sd421657428;
			5'd1:  a = 32'sd248918915;
			5'd2:  a = 32'sd131521918;
			5'd3:  a = 32'sd66762579;
			5'd4:  a = 32'sd33510843;
			5'd5:  a = 32'sd16771758;
			5'd6:  a = 32'sd8387925;
			5'd7:  a = 32'sd4194219;
			5'd8:  a = 32'sd2097141;
			5'd9:  a = 32'sd1048575;
			5'd10: a = 32'sd524288;
			5'd11: a = 32'sd262144;
			5'd12: a = 32'sd131072;
			5'd13: a = 32'sd65536;
			5'd14: a = 32'sd32768;
			5'd15: a = 32'sd16384;
			5'd16: a = 32'sd8192;
			5'd17: a = 32'sd4096;
			5'd18: a = 32'sd2048;
			5'd19: a = 32'sd1024;
			5'd20: a = 32'sd512;
			5'd21: a = 32'sd256;
			5'd22: a = 32'sd128;
			5'd23: a = 32'sd64;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

[rtl/core/gtg_front.sv]
// Front end: takes a pose, forms the offset to the goal and classifies its quadrant.
// Depends on gtg_pkg.
module gtg_front import gtg_pkg::*; (
	input  logic               start,
	input  logic               full,
	input  logic signed [15:0] pose_x,
	input  logic signed [15:0] pose_y,
	input  logic signed [15:0] heading,
	input  logic signed [15:0] target_x,
	input  logic signed [15:0] target_y,
	output logic               push,
	output item_t              item
);

	logic signed [DW-1:0] dx;
	logic signed [DW-1:0] dy;

	assign dx   = DW'(target_x) - DW'(pose_x);
	assign dy   = DW'(target_y) - DW'(pose_y);
	assign push = start && !full;

	always_comb begin
		item.dx      = dx;
		item.dy      = dy;
		item.heading = heading;
		item.zero    = (dx == '0) && (dy == '0);
		if (!dx[DW-1]) begin
			item.quad = QD_RIGHT;
		end else if (!dy[DW-1]) begin
			item.quad = QD_LEFT_UP;
		end else begin
			item.quad = QD_LEFT_DOWN;
		end
	end

endmodule

[rtl/core/gtg_queue.sv]
// Two-entry queue between front and back end.
// Depends on gtg_pkg.
module gtg_queue import gtg_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t wdata,
	input  logic  pop,
	output item_t rdata,
	output logic  full,
	output logic  empty
);

	item_t      mem_q [0:1];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       do_pop;

	assign full   = (cnt_q == 2'd2);
	assign empty  = (cnt_q == 2'd0);
	assign do_pop = pop && !empty;
	assign rdata  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (do_pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(do_pop);
		end
	end

endmodule

[rtl/core/gtg_back.sv]
// Back end: squares, digit-serial root and vectoring CORDIC in one pipeline,
// then gain multiply and saturation. Depends on gtg_pkg.
module gtg_back import gtg_pkg::*; #(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  item_t              in_item,
	input  logic [15:0]        linear_gain,
	input  logic [15:0]        angular_gain,
	input  logic [15:0]        stop_threshold,
	output logic               done,
	output logic [15:0]        linear_speed,
	output logic signed [15:0] turn_rate,
	output logic               arrived
);

	localparam int D = (CORDIC_STAGES > SQRT_STAGES) ? CORDIC_STAGES : SQRT_STAGES;

	// stage 1: squares and quadrant pre-rotation
	logic                    vld_s1;
	logic [33:0]             sqx_s1;
	logic [33:0]             sqy_s1;
	logic signed [XW-1:0]    x_s1;
	logic signed [XW-1:0]    y_s1;
	logic signed [ZW-1:0]    z_s1;
	logic signed [15:0]      hd_s1;
	logic                    zr_s1;

	logic signed [33:0]      dxw;
	logic signed [33:0]      dyw;
	logic signed [XW-1:0]    xd;
	logic signed [XW-1:0]    yd;

	assign dxw = 34'(in_item.dx);
	assign dyw = 34'(in_item.dy);
	assign xd  = XW'(in_item.dx) <<< 8;
	assign yd  = XW'(in_item.dy) <<< 8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		sqx_s1 <= 34'(dxw * dxw);
		sqy_s1 <= 34'(dyw * dyw);
		hd_s1  <= in_item.heading;
		zr_s1  <= in_item.zero;
		unique case (in_item.quad)
			QD_LEFT_UP: begin
				x_s1 <= yd;
				y_s1 <= -xd;
				z_s1 <= HALF_PI_Q29;
			end
			QD_LEFT_DOWN: begin
				x_s1 <= -yd;
				y_s1 <= xd;
				z_s1 <= -HALF_PI_Q29;
			end
			default: begin
				x_s1 <= xd;
				y_s1 <= yd;
				z_s1 <= '0;
			end
		endcase
	end

	// stage 2: root and CORDIC steps
	logic [D:0]           vld_s2;
	logic [33:0]          v_s2  [0:D];
	logic [34:0]          r_s2  [0:D];
	logic signed [XW-1:0] x_s2  [0:D];
	logic signed [XW-1:0] y_s2  [0:D];
	logic signed [ZW-1:0] z_s2  [0:D];
	logic signed [15:0]   hd_s2 [0:D];
	logic [D:0]           zr_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2[0] <= 1'b0;
		end else begin
			vld_s2[0] <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		v_s2[0]  <= sqx_s1 + sqy_s1;
		r_s2[0]  <= '0;
		x_s2[0]  <= x_s1;
		y_s2[0]  <= y_s1;
		z_s2[0]  <= z_s1;
		hd_s2[0] <= hd_s1;
		zr_s2[0] <= zr_s1;
	end

	for (genvar i = 0; i < D; i++) begin : g_stage
		logic [33:0]          v_n;
		logic [34:0]          r_n;
		logic signed [XW-1:0] x_n;
		logic signed [XW-1:0] y_n;
		logic signed [ZW-1:0] z_n;

		if (i < SQRT_STAGES) begin : g_sq
			localparam logic [34:0] B = 35'(1) << (2 * (SQRT_STAGES - 1 - i));
			logic [34:0] t;
			assign t = r_s2[i] + B;
			always_comb begin
				if (35'(v_s2[i]) >= t) begin
					v_n = v_s2[i] - t[33:0];
					r_n = (r_s2[i] >> 1) + B;
				end else begin
					v_n = v_s2[i];
					r_n = r_s2[i] >> 1;
				end
			end
		end else begin : g_sq_pass
			assign v_n = v_s2[i];
			assign r_n = r_s2[i];
		end

		if (i < CORDIC_STAGES) begin : g_cr
			logic signed [XW-1:0] xs;
			logic signed [XW-1:0] ys;
			assign xs = x_s2[i] >>> i;
			assign ys = y_s2[i] >>> i;
			always_comb begin
				if (!y_s2[i][XW-1]) begin
					x_n = x_s2[i] + ys;
					y_n = y_s2[i] - xs;
					z_n = z_s2[i] + atan_q29(5'(i));
				end else begin
					x_n = x_s2[i] - ys;
					y_n = y_s2[i] + xs;
					z_n = z_s2[i] - atan_q29(5'(i));
				end
			end
		end else begin : g_cr_pass
			assign x_n = x_s2[i];
			assign y_n = y_s2[i];
			assign z_n = z_s2[i];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s2[i+1] <= 1'b0;
			end else begin
				vld_s2[i+1] <= vld_s2[i];
			end
		end

		always_ff @(posedge clk) begin
			v_s2[i+1]  <= v_n;
			r_s2[i+1]  <= r_n;
			x_s2[i+1]  <= x_n;
			y_s2[i+1]  <= y_n;
			z_s2[i+1]  <= z_n;
			hd_s2[i+1] <= hd_s2[i];
			zr_s2[i+1] <= zr_s2[i];
		end
	end

	// stage 3: bearing rounding, heading error, arrival test
	logic                 vld_s3;
	logic [16:0]          dist_s3;
	logic signed [17:0]   err_s3;
	logic                 arr_s3;

	logic signed [ZW:0]   zsum;
	logic signed [16:0]   bear;
	logic [16:0]          dist_w;

	assign zsum   = (ZW+1)'(z_s2[D]) + 33'sd32768;
	assign bear   = zr_s2[D] ? 17'sd0 : zsum[32:16];
	assign dist_w = r_s2[D][16:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2[D];
		end
	end

	always_ff @(posedge clk) begin
		dist_s3 <= dist_w;
		err_s3  <= 18'(bear) - 18'(hd_s2[D]);
		arr_s3  <= dist_w < 17'(stop_threshold);
	end

	// stage 4: gain products
	logic                 vld_s4;
	logic [32:0]          lp_s4;
	logic signed [34:0]   tp_s4;
	logic                 arr_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		lp_s4  <= 33'(dist_s3) * 33'(linear_gain);
		tp_s4  <= 35'(err_s3) * $signed(35'(angular_gain));
		arr_s4 <= arr_s3;
	end

	// output register: scaling and saturation
	logic [20:0]        lq;
	logic signed [20:0] tq;
	logic [15:0]        lin_sat;
	logic signed [15:0] turn_sat;
	logic               done_q;
	logic [15:0]        lin_q;
	logic signed [15:0] turn_q;
	logic               arr_q;

	assign lq = lp_s4[32:12];
	assign tq = tp_s4[34:14];

	always_comb begin
		lin_sat = (|lq[20:16]) ? 16'hFFFF : lq[15:0];
		if (!tq[20] && (|tq[19:15])) begin
			turn_sat = 16'sh7FFF;
		end else if (tq[20] && !(&tq[19:15])) begin
			turn_sat = -16'sh8000;
		end else begin
			turn_sat = tq[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		lin_q  <= arr_s4 ? 16'd0 : lin_sat;
		turn_q <= arr_s4 ? 16'sd0 : turn_sat;
		arr_q  <= arr_s4;
	end

	assign done         = done_q;
	assign linear_speed = lin_q;
	assign turn_rate    = turn_q;
	assign arrived      = arr_q;

endmodule

[rtl/core/go_to_goal_velocity_controller_top.sv]
// Go-to-goal velocity controller, top level: config registers, front, queue, back.
// The done strobe follows the queue, stages 1 to 4 of the back end (with the root and
// CORDIC chain in stage 2) and the output register. Throughput one pose per cycle,
// set by the fully pipelined root and CORDIC chain; busy stays low since the back
// end drains the queue every cycle.
// Reset (asynchronous, active low) empties the queue and pipeline and loads the
// default goal, gains and threshold. Results cannot be stalled by the receiver.
module go_to_goal_velocity_controller_top import gtg_pkg::*; #(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] pose_x,
	input  logic signed [15:0] pose_y,
	input  logic signed [15:0] heading,
	input  logic               cfg_we,
	input  logic [CFG_AW-1:0]  cfg_addr,
	input  logic [15:0]        cfg_wdata,
	output logic               done,
	output logic [15:0]        linear_speed,
	output logic signed [15:0] turn_rate,
	output logic               arrived
);

	localparam int D   = (CORDIC_STAGES > SQRT_STAGES) ? CORDIC_STAGES : SQRT_STAGES;
	localparam int LAT = D + 6;

	logic [15:0] target_x_q;
	logic [15:0] target_y_q;
	logic [15:0] lin_gain_q;
	logic [15:0] ang_gain_q;
	logic [15:0] stop_thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_x_q <= RST_TARGET_X;
			target_y_q <= RST_TARGET_Y;
			lin_gain_q <= RST_LINEAR_GAIN;
			ang_gain_q <= RST_ANGULAR_GAIN;
			stop_thr_q <= RST_STOP_THR;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_addr))
				REG_TARGET_X:     target_x_q <= cfg_wdata;
				REG_TARGET_Y:     target_y_q <= cfg_wdata;
				REG_LINEAR_GAIN:  lin_gain_q <= cfg_wdata;
				REG_ANGULAR_GAIN: ang_gain_q <= cfg_wdata;
				REG_STOP_THR:     stop_thr_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	logic  push;
	item_t fr_item;
	item_t q_item;
	logic  q_full;
	logic  q_empty;

	gtg_front u_front (
		.start    (start),
		.full     (q_full),
		.pose_x   (pose_x),
		.pose_y   (pose_y),
		.heading  (heading),
		.target_x ($signed(target_x_q)),
		.target_y ($signed(target_y_q)),
		.push     (push),
		.item     (fr_item)
	);

	gtg_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (fr_item),
		.pop    (!q_empty),
		.rdata  (q_item),
		.full   (q_full),
		.empty  (q_empty)
	);

	gtg_back #(
		.CORDIC_STAGES (CORDIC_STAGES)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (!q_empty),
		.in_item        (q_item),
		.linear_gain    (lin_gain_q),
		.angular_gain   (ang_gain_q),
		.stop_threshold (stop_thr_q),
		.done           (done),
		.linear_speed   (linear_speed),
		.turn_rate      (turn_rate),
		.arrived        (arrived)
	);

	assign busy = q_full;

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("queue filled although back end drains every cycle");

	a_arrived_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && arrived) |-> (linear_speed == 16'd0 && turn_rate == 16'sd0))
		else $error("arrived result carries non-zero command");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without matching transfer");

endmodule
